// File: hdl/rmsd_pkg.sv
// Shared constants and handshake structs for the frame RMSD engine.
package rmsd_pkg;

    localparam int MAX_ATOMS  = 4096;
    localparam int COORD_BITS = 24;

    localparam int ATOM_W  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W   = 13;
    localparam int CMP_W   = (ATOM_W + 1 > CNT_W) ? ATOM_W + 1 : CNT_W;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = 64;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int FRAME_W = 16;
    localparam int RMSD_W  = 25;
    localparam int REF_W   = 3 * COORD_BITS;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } math_req_t;

    typedef struct packed {
        logic              done;
        logic [RMSD_W-1:0] root;
    } math_resp_t;

endpackage

// File: hdl/rmsd_ram.sv
// Generic single-port RAM with registered read.
module rmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/rmsd_divsqrt.sv
// Serial mean and floor square root sharing one wide subtractor.
module rmsd_divsqrt
    import rmsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  math_req_t  req,
    output math_resp_t resp
);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_DIV  = 4'b0010,
        P_SQRT = 4'b0100,
        P_DONE = 4'b1000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   div_reg, div_next;
    logic [SUM_W-1:0]   root_reg, root_next;
    logic [SUM_W-1:0]   bit_reg, bit_next;

    logic [SUM_W-1:0]   op_a;
    logic [SUM_W-1:0]   op_b;
    logic [SUM_W:0]     sub;
    logic               ge;

    // shared subtractor: trial remainder while dividing, trial root while rooting
    always_comb
    begin
        case (phase_reg)
            P_DIV:
            begin
                op_a = SUM_W'({rem_reg, q_reg[SUM_W-1]});
                op_b = SUM_W'(div_reg);
            end
            P_SQRT:
            begin
                op_a = q_reg;
                op_b = root_reg | bit_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        sub = {1'b0, op_a} - {1'b0, op_b};
        ge  = ~sub[SUM_W];
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        case (phase_reg)
            P_DIV:
            begin
                q_next   = {q_reg[SUM_W-2:0], ge};
                rem_next = ge ? sub[CNT_W-1:0] : op_a[CNT_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SUM_W - 1))
                begin
                    phase_next = P_SQRT;
                    cnt_next   = '0;
                    root_next  = '0;
                    bit_next   = SUM_W'(1) << (SUM_W - 2);
                end
            end
            P_SQRT:
            begin
                if (ge)
                begin
                    q_next    = sub[SUM_W-1:0];
                    root_next = (root_reg >> 1) | bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SUM_W / 2 - 1))
                begin
                    phase_next = P_DONE;
                end
            end
            default:
            begin
            end
        endcase
        if (req.start)
        begin
            phase_next = P_DIV;
            cnt_next   = '0;
            q_next     = req.sum;
            rem_next   = '0;
            div_next   = req.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign resp.done = (phase_reg == P_DONE);
    assign resp.root = (root_reg[SUM_W-1:RMSD_W] != '0) ? {RMSD_W{1'b1}}
                                                         : root_reg[RMSD_W-1:0];

endmodule

// File: hdl/frame_rmsd_engine.sv
// Top level of the frame RMSD engine: reference store, squared-difference sequencer, output.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | atom_count
//  in      | in        | in_valid/in_stall    | start_trajectory, x_pos, y_pos, z_pos
//  out     | out       | out_valid/out_stall  | frame_index, rmsd
//
//  Reference-frame atom: RAM write, then counter update.
//  Other atoms: one multiplier does x, y, z in turn (diff, square, add).
//  Last atom of a frame: a restoring divide and then a square root
//  on one shared 64-bit subtractor, then a result load once the output is free.
//  Reset clears the control state; the reference RAM has no reset.
//  A stalled result blocks the load of the next frame's result, and with it new input.
module frame_rmsd_engine
    import rmsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      atom_count,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  start_trajectory,
    input  logic [COORD_BITS-1:0] x_pos,
    input  logic [COORD_BITS-1:0] y_pos,
    input  logic [COORD_BITS-1:0] z_pos,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FRAME_W-1:0]    frame_index,
    output logic [RMSD_W-1:0]     rmsd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIFF  = 6'b000010,
        S_MUL   = 6'b000100,
        S_ACC   = 6'b001000,
        S_CHECK = 6'b010000,
        S_MATH  = 6'b100000
    } state_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ATOM_W-1:0]     atom_reg, atom_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic [FRAME_W-1:0]    hold_reg, hold_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  in_ref_reg, in_ref_next;
    logic [1:0]            axis_reg, axis_next;
    logic [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic [DIFF_W-1:0]     absd_reg, absd_next;
    logic [PROD_W-1:0]     prod_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]    frame_out_reg, frame_out_next;
    logic [RMSD_W-1:0]     rmsd_out_reg, rmsd_out_next;

    logic                  accept;
    logic                  ref_now;
    logic [ATOM_W-1:0]     slot;
    logic [REF_W-1:0]      ref_data;
    logic [CMP_W-1:0]      eff_count;
    logic [CMP_W-1:0]      next_idx;
    logic                  last_atom;
    logic                  out_free;
    logic [COORD_BITS-1:0] cur_c, ref_c;
    logic signed [DIFF_W-1:0] diff;
    logic [SUM_W:0]        acc;
    math_req_t             req;
    math_resp_t            resp;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign ref_now   = start_trajectory || in_ref_reg;
    assign slot      = start_trajectory ? '0 : atom_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    rmsd_ram #(
        .WIDTH (REF_W),
        .DEPTH (MAX_ATOMS)
    ) u_ref_ram (
        .clk   (clk),
        .en    (accept),
        .we    (ref_now),
        .addr  (slot),
        .wdata ({x_pos, y_pos, z_pos}),
        .rdata (ref_data)
    );

    rmsd_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .resp  (resp)
    );

    // zero counts as one atom, large counts saturate to the store depth
    always_comb
    begin
        eff_count = CMP_W'(count_reg);
        if (count_reg == '0)
        begin
            eff_count = CMP_W'(1);
        end
        else if (CMP_W'(count_reg) > CMP_W'(MAX_ATOMS))
        begin
            eff_count = CMP_W'(MAX_ATOMS);
        end
        next_idx  = CMP_W'(atom_reg) + CMP_W'(1);
        last_atom = (next_idx >= eff_count);
    end

    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                cur_c = x_reg;
                ref_c = ref_data[3*COORD_BITS-1:2*COORD_BITS];
            end
            AXIS_Y:
            begin
                cur_c = y_reg;
                ref_c = ref_data[2*COORD_BITS-1:COORD_BITS];
            end
            AXIS_Z:
            begin
                cur_c = z_reg;
                ref_c = ref_data[COORD_BITS-1:0];
            end
            default:
            begin
                cur_c = '0;
                ref_c = '0;
            end
        endcase
        diff      = $signed({cur_c[COORD_BITS-1], cur_c}) - $signed({ref_c[COORD_BITS-1], ref_c});
        absd_next = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        acc       = {1'b0, sum_reg} + (SUM_W + 1)'(prod_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        atom_next      = atom_reg;
        frame_next     = frame_reg;
        hold_next      = hold_reg;
        sum_next       = sum_reg;
        in_ref_next    = in_ref_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && out_stall;
        frame_out_next = frame_out_reg;
        rmsd_out_next  = rmsd_out_reg;
        req.start      = 1'b0;
        req.sum        = sum_reg;
        req.count      = CNT_W'(eff_count);

        if (cfg_valid && cfg_ready)
        begin
            count_next = atom_count;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    atom_next   = slot;
                    in_ref_next = ref_now;
                    axis_next   = AXIS_X;
                    if (start_trajectory)
                    begin
                        frame_next = '0;
                        sum_next   = '0;
                    end
                    state_next = ref_now ? S_CHECK : S_DIFF;
                end
            end
            S_DIFF:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
                if (axis_reg == AXIS_Z)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DIFF;
                end
            end
            S_CHECK:
            begin
                if (!last_atom)
                begin
                    atom_next  = atom_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    req.start   = 1'b1;
                    hold_next   = frame_reg;
                    frame_next  = frame_reg + 1'b1;
                    atom_next   = '0;
                    sum_next    = '0;
                    in_ref_next = 1'b0;
                    state_next  = S_MATH;
                end
            end
            S_MATH:
            begin
                if (resp.done && out_free)
                begin
                    out_valid_next = 1'b1;
                    frame_out_next = hold_reg;
                    rmsd_out_next  = resp.root;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            atom_reg      <= '0;
            frame_reg     <= '0;
            sum_reg       <= '0;
            in_ref_reg    <= 1'b1;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            atom_reg      <= atom_next;
            frame_reg     <= frame_next;
            sum_reg       <= sum_next;
            in_ref_reg    <= in_ref_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= x_pos;
            y_reg <= y_pos;
            z_reg <= z_pos;
        end
        hold_reg      <= hold_next;
        absd_reg      <= absd_next;
        prod_reg      <= absd_reg * absd_reg;
        frame_out_reg <= frame_out_next;
        rmsd_out_reg  <= rmsd_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign frame_index = frame_out_reg;
    assign rmsd        = rmsd_out_reg;

endmodule
